// ===== rtl/stepper_ramp_profile_generator_macros.svh =====
// Assertion macros shared by the stepper ramp generator RTL.
// Depends on nothing; files that assert take it with an include.
`ifndef STEPPER_RAMP_PROFILE_GENERATOR_MACROS_SVH
`define STEPPER_RAMP_PROFILE_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SRPG_ASSERT_IMP(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (c)) \
    else $error("srpg assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SRPG_ASSERT_NXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (c)) \
    else $error("srpg assertion failed");

`endif

// ===== rtl/srpg_pkg.sv =====
// Package for the stepper ramp generator: payload structs, codes, constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package srpg_pkg;

  // Default parameter values
  localparam int TimerClockHzDef = 72000000;
  localparam int SpeedStepsDef   = 2048;
  localparam int StallLimitDef   = 20;

  // Datapath widths
  localparam int SpeedW = 11;
  localparam int CountW = 32;
  localparam int DvdW   = 32;
  localparam int DvsW   = 22;
  localparam int StallW = 5;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  // Item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_PULSE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_STOP  = 2'd3;

  // Motor phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_ACCEL  = 2'd1;
  localparam logic [1:0] PH_CRUISE = 2'd2;
  localparam logic [1:0] PH_DECEL  = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SEG1_TOP  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SEG2_TOP  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SEG3_TOP  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SEG1_RATE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SEG2_RATE = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SEG3_RATE = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_LOW_FREQ  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_FREQ_IDX  = 3'd7;

  // Register reset values
  localparam logic [10:0] SEG1_TOP_RST  = 11'd300;
  localparam logic [10:0] SEG2_TOP_RST  = 11'd1000;
  localparam logic [10:0] SEG3_TOP_RST  = 11'd1344;
  localparam logic [7:0]  SEG1_RATE_RST = 8'd4;
  localparam logic [7:0]  SEG2_RATE_RST = 8'd6;
  localparam logic [7:0]  SEG3_RATE_RST = 8'd8;
  localparam logic [15:0] LOW_FREQ_RST  = 16'd1000;
  localparam logic [9:0]  FREQ_IDX_RST  = 10'd10;

  localparam logic [SpeedW-1:0] SPEED_MAX = 11'd2047;

  typedef struct packed {
    logic [1:0]         kind;
    logic [10:0]        start_speed;
    logic [10:0]        top_speed;
    logic [31:0]        step_target;
    logic               direction_up;
    logic signed [31:0] encoder_count;
    logic [15:0]        encoder_speed;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  motor_phase;
    logic [10:0] speed_index;
    logic [15:0] period_ticks;
    logic [31:0] steps_done;
    logic        stall_error;
    logic        move_up;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       update;
    logic       div_start;
    logic       div_per;
    logic [1:0] seg_sel;
    logic       acc_add;
    logic       speed_wr;
    logic       period_wr;
    logic       out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       ramp_need;
    logic [1:0] upto;
    logic       div_done;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/srpg_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on srpg_pkg for widths.
`default_nettype none

module srpg_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [srpg_pkg::DvdW-1:0] dividend,
  input  wire logic [srpg_pkg::DvsW-1:0] divisor,
  output logic                           done,
  output logic [srpg_pkg::DvdW-1:0]      quotient
);

  logic                      busy_r, done_r;
  logic [4:0]                cnt_r;
  logic [srpg_pkg::DvsW:0]   rem_r;
  logic [srpg_pkg::DvsW-1:0] dvs_r;
  logic [srpg_pkg::DvdW-1:0] quo_r;
  logic [srpg_pkg::DvsW:0]   trial;
  logic                      fits;

  assign trial = {rem_r[srpg_pkg::DvsW-1:0], quo_r[srpg_pkg::DvdW-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // zero divisor yields all ones, which the caller saturates
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? trial - {1'b0, dvs_r} : trial;
      quo_r <= {quo_r[srpg_pkg::DvdW-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== rtl/srpg_datapath.sv =====
// Datapath: config registers, motion state, item update, ramp and period math.
// Depends on srpg_pkg and srpg_div.
`default_nettype none

module srpg_datapath #(
  parameter int TIMER_CLOCK_HZ = srpg_pkg::TimerClockHzDef,
  parameter int SPEED_STEPS    = srpg_pkg::SpeedStepsDef,
  parameter int STALL_LIMIT    = srpg_pkg::StallLimitDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [srpg_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [srpg_pkg::CfgDataW-1:0] cfg_data,
  input  wire srpg_pkg::in_item_t            in_data,
  input  wire srpg_pkg::cmd_t                cmd,
  output srpg_pkg::stat_t                    stat,
  output srpg_pkg::out_item_t                out_data
);

  // configuration
  logic [10:0] seg1_top_r, seg2_top_r, seg3_top_r;
  logic [7:0]  seg1_rate_r, seg2_rate_r, seg3_rate_r;
  logic [15:0] low_freq_r;
  logic [9:0]  freq_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg1_top_r  <= srpg_pkg::SEG1_TOP_RST;
      seg2_top_r  <= srpg_pkg::SEG2_TOP_RST;
      seg3_top_r  <= srpg_pkg::SEG3_TOP_RST;
      seg1_rate_r <= srpg_pkg::SEG1_RATE_RST;
      seg2_rate_r <= srpg_pkg::SEG2_RATE_RST;
      seg3_rate_r <= srpg_pkg::SEG3_RATE_RST;
      low_freq_r  <= srpg_pkg::LOW_FREQ_RST;
      freq_idx_r  <= srpg_pkg::FREQ_IDX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        srpg_pkg::REG_SEG1_TOP:  seg1_top_r  <= cfg_data[10:0];
        srpg_pkg::REG_SEG2_TOP:  seg2_top_r  <= cfg_data[10:0];
        srpg_pkg::REG_SEG3_TOP:  seg3_top_r  <= cfg_data[10:0];
        srpg_pkg::REG_SEG1_RATE: seg1_rate_r <= cfg_data[7:0];
        srpg_pkg::REG_SEG2_RATE: seg2_rate_r <= cfg_data[7:0];
        srpg_pkg::REG_SEG3_RATE: seg3_rate_r <= cfg_data[7:0];
        srpg_pkg::REG_LOW_FREQ:  low_freq_r  <= cfg_data[15:0];
        srpg_pkg::REG_FREQ_IDX:  freq_idx_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // motion state
  srpg_pkg::in_item_t item_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [10:0] speed_r, speed_nxt, limit_r, limit_nxt, base_r, base_nxt;
  logic [31:0] target_r, target_nxt, step_r, step_nxt, origin_r, origin_nxt;
  logic [31:0] seg_cnt_r [3];
  logic [31:0] seg_cnt_nxt [3];
  logic [srpg_pkg::StallW-1:0] stall_r, stall_nxt;
  logic        err_r, err_nxt, dir_r, dir_nxt;
  logic        need_nxt;
  logic [1:0]  upto_nxt, upto_r;
  logic [10:0] acc_r;
  logic [15:0] period_r;
  srpg_pkg::out_item_t out_r;

  logic [31:0] cnt_inc;
  logic [32:0] diff, dist_abs;
  logic [37:0] dist25;
  logic [20:0] run_prod;
  logic [21:0] run;
  logic [22:0] act_prod;
  logic [20:0] act2;

  assign cnt_inc  = step_r + 32'd1;
  assign diff     = {item_r.encoder_count[31], item_r.encoder_count}
                  - {origin_r[31], origin_r};
  assign dist_abs = diff[32] ? (33'd0 - diff) : diff;
  assign dist25   = {1'b0, dist_abs, 4'b0} + {2'b0, dist_abs, 3'b0} + {5'b0, dist_abs};
  assign run_prod = speed_r * freq_idx_r;
  assign run      = {6'b0, low_freq_r} + {1'b0, run_prod};
  assign act_prod = item_r.encoder_speed * 7'd125;
  assign act2     = {act_prod[22:3], 1'b0};

  always_comb begin
    phase_nxt  = phase_r;
    speed_nxt  = speed_r;
    limit_nxt  = limit_r;
    base_nxt   = base_r;
    target_nxt = target_r;
    step_nxt   = step_r;
    origin_nxt = origin_r;
    stall_nxt  = stall_r;
    err_nxt    = err_r;
    dir_nxt    = dir_r;
    need_nxt   = 1'b0;
    upto_nxt   = 2'd0;
    for (int k = 0; k < 3; k++) seg_cnt_nxt[k] = seg_cnt_r[k];
    case (item_r.kind)
      srpg_pkg::KIND_START: begin
        dir_nxt    = item_r.direction_up;
        step_nxt   = '0;
        for (int k = 0; k < 3; k++) seg_cnt_nxt[k] = '0;
        phase_nxt  = srpg_pkg::PH_ACCEL;
        err_nxt    = 1'b0;
        base_nxt   = item_r.start_speed;
        speed_nxt  = item_r.start_speed;
        target_nxt = item_r.step_target;
        limit_nxt  = item_r.top_speed;
        origin_nxt = item_r.encoder_count;
      end
      srpg_pkg::KIND_PULSE: begin
        if (phase_r != srpg_pkg::PH_IDLE) begin
          step_nxt = cnt_inc;
          if (cnt_inc >= target_r) begin
            phase_nxt = srpg_pkg::PH_IDLE;
          end else begin
            case (phase_r)
              srpg_pkg::PH_ACCEL: begin
                if (speed_r < limit_r) begin
                  if (speed_r < seg1_top_r) begin
                    seg_cnt_nxt[0] = seg_cnt_r[0] + 32'd1;
                    need_nxt = 1'b1;
                    upto_nxt = 2'd0;
                  end else if (speed_r < seg2_top_r) begin
                    seg_cnt_nxt[1] = seg_cnt_r[1] + 32'd1;
                    need_nxt = 1'b1;
                    upto_nxt = 2'd1;
                  end else if (speed_r < seg3_top_r) begin
                    seg_cnt_nxt[2] = seg_cnt_r[2] + 32'd1;
                    need_nxt = 1'b1;
                    upto_nxt = 2'd2;
                  end
                end else begin
                  phase_nxt = srpg_pkg::PH_CRUISE;
                end
              end
              srpg_pkg::PH_CRUISE: begin
                if (target_r - cnt_inc < {21'b0, speed_r}) phase_nxt = srpg_pkg::PH_DECEL;
              end
              default: begin
                if (speed_r != '0) speed_nxt = speed_r - 11'd1;
              end
            endcase
          end
        end
      end
      srpg_pkg::KIND_TICK: begin
        if (phase_r == srpg_pkg::PH_IDLE) begin
          stall_nxt = '0;
        end else begin
          step_nxt = dist25[37:6];
          if (run > {1'b0, act2}) begin
            if (stall_r < srpg_pkg::StallW'(STALL_LIMIT)) begin
              stall_nxt = stall_r + 1'b1;
            end else begin
              err_nxt   = 1'b1;
              phase_nxt = srpg_pkg::PH_IDLE;
            end
          end else begin
            stall_nxt = '0;
          end
        end
      end
      default: phase_nxt = srpg_pkg::PH_IDLE;
    endcase
  end

  // divider operand selection
  logic [7:0]  rate_raw, rate;
  logic [12:0] idx_wide;
  logic [10:0] idx;
  logic [20:0] den_prod;
  logic [21:0] den;
  logic [31:0] dvd;
  logic [21:0] dvs;
  logic        div_done;
  logic [31:0] quo;
  logic [11:0] acc_sum;

  always_comb begin
    case (cmd.seg_sel)
      2'd0:    rate_raw = seg1_rate_r;
      2'd1:    rate_raw = seg2_rate_r;
      default: rate_raw = seg3_rate_r;
    endcase
  end

  assign rate     = (rate_raw == 8'd0) ? 8'd1 : rate_raw;
  assign idx_wide = ({2'b0, speed_r} > 13'(SPEED_STEPS - 1)) ? 13'(SPEED_STEPS - 1)
                                                             : {2'b0, speed_r};
  assign idx      = idx_wide[10:0];
  assign den_prod = idx * freq_idx_r;
  assign den      = {6'b0, low_freq_r} + {1'b0, den_prod};
  assign dvd      = cmd.div_per ? 32'(TIMER_CLOCK_HZ)
                                : seg_cnt_r[cmd.seg_sel == 2'd3 ? 2'd2 : cmd.seg_sel];
  assign dvs      = cmd.div_per ? den : {14'b0, rate};
  assign acc_sum  = {1'b0, acc_r} + {1'b0, quo[10:0]};

  srpg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= srpg_pkg::PH_IDLE;
      speed_r  <= '0;
      limit_r  <= '0;
      base_r   <= '0;
      target_r <= '0;
      step_r   <= '0;
      origin_r <= '0;
      stall_r  <= '0;
      err_r    <= 1'b0;
      dir_r    <= 1'b0;
      for (int k = 0; k < 3; k++) seg_cnt_r[k] <= '0;
    end else if (cmd.update) begin
      phase_r  <= phase_nxt;
      speed_r  <= speed_nxt;
      limit_r  <= limit_nxt;
      base_r   <= base_nxt;
      target_r <= target_nxt;
      step_r   <= step_nxt;
      origin_r <= origin_nxt;
      stall_r  <= stall_nxt;
      err_r    <= err_nxt;
      dir_r    <= dir_nxt;
      for (int k = 0; k < 3; k++) seg_cnt_r[k] <= seg_cnt_nxt[k];
    end else if (cmd.speed_wr) begin
      speed_r <= acc_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.update) begin
      upto_r <= upto_nxt;
      acc_r  <= base_r;
    end else if (cmd.acc_add) begin
      // running sum saturates; all terms are non-negative
      if (quo[31:11] != '0 || acc_sum[11]) acc_r <= srpg_pkg::SPEED_MAX;
      else acc_r <= acc_sum[10:0];
    end
    if (cmd.period_wr) period_r <= (quo[31:16] != '0) ? 16'hFFFF : quo[15:0];
    if (cmd.out_load) begin
      out_r.motor_phase  <= phase_r;
      out_r.speed_index  <= speed_r;
      out_r.period_ticks <= period_r;
      out_r.steps_done   <= step_r;
      out_r.stall_error  <= err_r;
      out_r.move_up      <= dir_r;
    end
  end

  assign stat.ramp_need = need_nxt;
  assign stat.upto      = upto_r;
  assign stat.div_done  = div_done;
  assign out_data       = out_r;

endmodule

`default_nettype wire

// ===== rtl/srpg_ctrl.sv =====
// Controller: sequences update, ramp divisions, period division and output.
// Depends on srpg_pkg and the assertion macro header.
`default_nettype none
`include "stepper_ramp_profile_generator_macros.svh"

module srpg_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire srpg_pkg::stat_t stat,
  output srpg_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_SEG  = 3'd2;
  localparam logic [2:0] S_SEGW = 3'd3;
  localparam logic [2:0] S_SPD  = 3'd4;
  localparam logic [2:0] S_PER  = 3'd5;
  localparam logic [2:0] S_PERW = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] seg_r, seg_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, out_free;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    seg_nxt       = seg_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.seg_sel   = seg_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        seg_nxt    = 2'd0;
        state_nxt  = stat.ramp_need ? S_SEG : S_PER;
      end
      S_SEG: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_SEGW;
      end
      S_SEGW: begin
        if (stat.div_done) begin
          cmd.acc_add = 1'b1;
          if (seg_r == stat.upto) begin
            state_nxt = S_SPD;
          end else begin
            seg_nxt   = seg_r + 2'd1;
            state_nxt = S_SEG;
          end
        end
      end
      S_SPD: begin
        cmd.speed_wr = 1'b1;
        state_nxt    = S_PER;
      end
      S_PER: begin
        cmd.div_start = 1'b1;
        cmd.div_per   = 1'b1;
        state_nxt     = S_PERW;
      end
      S_PERW: begin
        cmd.div_per = 1'b1;
        if (stat.div_done) begin
          cmd.period_wr = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seg_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `SRPG_ASSERT_NXT(a_accept_updates, clk, rst_n, accept, state_r == S_UPD)
  `SRPG_ASSERT_NXT(a_done_loads_out, clk, rst_n, state_r == S_DONE && out_free, out_valid_r)
  `SRPG_ASSERT_NXT(a_last_seg_speed, clk, rst_n,
    state_r == S_SEGW && stat.div_done && seg_r == stat.upto, state_r == S_SPD)
  `SRPG_ASSERT_IMP(a_seg_in_range, clk, rst_n, state_r == S_SEGW, seg_r <= stat.upto)

endmodule

`default_nettype wire

// ===== rtl/stepper_ramp_profile_generator.sv =====
// Top level of the stepper ramp generator: controller plus datapath.
// Depends on srpg_pkg, srpg_ctrl, srpg_datapath (and srpg_div below it).
//
//   channel  ports                          role
//   in       in_valid, in_stall, in_data    command items (start/pulse/tick/stop)
//   out      out_valid, out_stall, out_data one status item per command
//   cfg      cfg_we, cfg_index, cfg_data    ramp and frequency registers
//
// One item at a time: each is loaded and updated; when a ramp step is due the k+1
// segment quotients are recomputed in turn, and then the period is divided.
// Reset is synchronous; no clearing pass.
// A result waits in the output register; the next item is taken meanwhile,
// and its own result is held back until the waiting one is transferred.
`default_nettype none

module stepper_ramp_profile_generator #(
  parameter int TIMER_CLOCK_HZ = srpg_pkg::TimerClockHzDef,
  parameter int SPEED_STEPS    = srpg_pkg::SpeedStepsDef,
  parameter int STALL_LIMIT    = srpg_pkg::StallLimitDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire srpg_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output srpg_pkg::out_item_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic [srpg_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [srpg_pkg::CfgDataW-1:0] cfg_data
);

  srpg_pkg::cmd_t  cmd;
  srpg_pkg::stat_t stat;

  srpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  srpg_datapath #(
    .TIMER_CLOCK_HZ (TIMER_CLOCK_HZ),
    .SPEED_STEPS    (SPEED_STEPS),
    .STALL_LIMIT    (STALL_LIMIT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== sim/stepper_ramp_profile_generator_tb.sv =====
// Self-checking bench for the stepper ramp generator: drives command items,
// predicts every status item and compares field by field. Depends on srpg_pkg
// and the stepper_ramp_profile_generator RTL.
`default_nettype none

module stepper_ramp_profile_generator_tb;

  localparam int TimerHz = srpg_pkg::TimerClockHzDef;
  localparam int StallLim = srpg_pkg::StallLimitDef;
  localparam int IdleLimit = 20000;

  class ramp_scoreboard;
    logic [10:0] seg_top[3];
    logic [7:0] seg_rate[3];
    logic [15:0] low_freq;
    logic [9:0] freq_idx;
    logic [1:0] phase;
    logic [10:0] speed_now, speed_limit, base_speed;
    logic [31:0] target_steps, step_count, origin;
    logic [31:0] seg_cnt[3];
    int unsigned stall_ticks;
    logic error_flag, direction;
    srpg_pkg::out_item_t pending[$];
    int errors, checked;

    function new();
      seg_top[0] = srpg_pkg::SEG1_TOP_RST; seg_top[1] = srpg_pkg::SEG2_TOP_RST;
      seg_top[2] = srpg_pkg::SEG3_TOP_RST;
      seg_rate[0] = srpg_pkg::SEG1_RATE_RST; seg_rate[1] = srpg_pkg::SEG2_RATE_RST;
      seg_rate[2] = srpg_pkg::SEG3_RATE_RST;
      low_freq = srpg_pkg::LOW_FREQ_RST; freq_idx = srpg_pkg::FREQ_IDX_RST;
      phase = srpg_pkg::PH_IDLE; speed_now = 0; speed_limit = 0; base_speed = 0;
      target_steps = 0; step_count = 0; origin = 0;
      for (int i = 0; i < 3; i++) seg_cnt[i] = 0;
      stall_ticks = 0; error_flag = 0; direction = 0;
      errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        srpg_pkg::REG_SEG1_TOP:  seg_top[0] = val[10:0];
        srpg_pkg::REG_SEG2_TOP:  seg_top[1] = val[10:0];
        srpg_pkg::REG_SEG3_TOP:  seg_top[2] = val[10:0];
        srpg_pkg::REG_SEG1_RATE: seg_rate[0] = val[7:0];
        srpg_pkg::REG_SEG2_RATE: seg_rate[1] = val[7:0];
        srpg_pkg::REG_SEG3_RATE: seg_rate[2] = val[7:0];
        srpg_pkg::REG_LOW_FREQ:  low_freq = val;
        srpg_pkg::REG_FREQ_IDX:  freq_idx = val[9:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] period_for(logic [10:0] spd);
      longint unsigned den, q;
      den = longint'(low_freq) + longint'(spd) * freq_idx;
      if (den == 0) return 16'hFFFF;
      q = TimerHz / den;
      return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    function logic [10:0] ramp_speed(int upto);
      longint unsigned s;
      s = base_speed;
      for (int i = 0; i <= upto; i++)
        s += seg_cnt[i] / ((seg_rate[i] == 0) ? 1 : seg_rate[i]);
      return (s > 2047) ? srpg_pkg::SPEED_MAX : s[10:0];
    endfunction

    function void step_pulse();
      if (phase == srpg_pkg::PH_IDLE) return;
      step_count++;
      if (step_count >= target_steps) begin
        phase = srpg_pkg::PH_IDLE;
        return;
      end
      case (phase)
        srpg_pkg::PH_ACCEL: begin
          if (speed_now < speed_limit) begin
            for (int i = 0; i < 3; i++) begin
              if (speed_now < seg_top[i]) begin
                seg_cnt[i]++;
                speed_now = ramp_speed(i);
                break;
              end
            end
          end else phase = srpg_pkg::PH_CRUISE;
        end
        srpg_pkg::PH_CRUISE:
          if (target_steps - step_count < speed_now) phase = srpg_pkg::PH_DECEL;
        default: if (speed_now > 0) speed_now--;
      endcase
    endfunction

    function void supervise(logic signed [31:0] enc, logic [15:0] enc_speed);
      longint d, dist_abs;
      longint unsigned cmd_rate, meas;
      if (phase == srpg_pkg::PH_IDLE) begin
        stall_ticks = 0;
        return;
      end
      d = longint'(enc) - longint'($signed(origin));
      dist_abs = (d < 0) ? -d : d;
      step_count = 32'((dist_abs * 25) >> 6);
      cmd_rate = longint'(low_freq) + longint'(speed_now) * freq_idx;
      meas = (longint'(enc_speed) * 125) >> 3;
      if (cmd_rate > 2 * meas) begin
        if (stall_ticks < StallLim) stall_ticks++;
        else begin
          error_flag = 1;
          phase = srpg_pkg::PH_IDLE;
        end
      end else stall_ticks = 0;
    endfunction

    function void note_input(srpg_pkg::in_item_t it);
      srpg_pkg::out_item_t r;
      case (it.kind)
        srpg_pkg::KIND_START: begin
          direction = it.direction_up;
          step_count = 0;
          for (int i = 0; i < 3; i++) seg_cnt[i] = 0;
          phase = srpg_pkg::PH_ACCEL; error_flag = 0;
          base_speed = it.start_speed; speed_now = it.start_speed;
          target_steps = it.step_target; speed_limit = it.top_speed;
          origin = it.encoder_count;
        end
        srpg_pkg::KIND_PULSE: step_pulse();
        srpg_pkg::KIND_TICK:  supervise(it.encoder_count, it.encoder_speed);
        default:              phase = srpg_pkg::PH_IDLE;
      endcase
      r.motor_phase = phase; r.speed_index = speed_now;
      r.period_ticks = period_for(speed_now); r.steps_done = step_count;
      r.stall_error = error_flag; r.move_up = direction;
      pending.push_back(r);
    endfunction

    function void check_result(srpg_pkg::out_item_t got);
      srpg_pkg::out_item_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected status item %p", $time, got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.motor_phase !== exp_r.motor_phase)
        $display("%0t: phase exp %0d got %0d", $time, exp_r.motor_phase, got.motor_phase);
      if (got.speed_index !== exp_r.speed_index)
        $display("%0t: speed exp %0d got %0d", $time, exp_r.speed_index, got.speed_index);
      if (got.period_ticks !== exp_r.period_ticks)
        $display("%0t: period exp %0d got %0d", $time, exp_r.period_ticks,
                 got.period_ticks);
      if (got.steps_done !== exp_r.steps_done)
        $display("%0t: steps exp %0d got %0d", $time, exp_r.steps_done, got.steps_done);
      if (got.stall_error !== exp_r.stall_error)
        $display("%0t: stall exp %0b got %0b", $time, exp_r.stall_error, got.stall_error);
      if (got.move_up !== exp_r.move_up)
        $display("%0t: dir exp %0b got %0b", $time, exp_r.move_up, got.move_up);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0, cfg_we = 0;
  srpg_pkg::in_item_t in_data = '0;
  srpg_pkg::out_item_t out_data;
  logic in_stall, out_valid;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  ramp_scoreboard sb = new();
  int send_idle_pct = 26, recv_idle_pct = 26;
  bit hold_recv = 0;
  int idle_cycles = 0;
  int n_starts = 0, n_pulses = 0, n_ticks = 0, n_stops = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  stepper_ramp_profile_generator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // result side: sample at rising edge, change stall at falling edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transfer for %0d cycles", IdleLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk)
    out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);

  task automatic send(srpg_pkg::in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    case (it.kind)
      srpg_pkg::KIND_START: n_starts++;
      srpg_pkg::KIND_PULSE: n_pulses++;
      srpg_pkg::KIND_TICK:  n_ticks++;
      default:              n_stops++;
    endcase
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, int unsigned val);
    logic [15:0] v;
    v = 16'(val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  function automatic srpg_pkg::in_item_t mk(logic [1:0] k);
    srpg_pkg::in_item_t it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(srpg_pkg::in_item_t)-1:0];
    it.kind = k;
    return it;
  endfunction

  function automatic srpg_pkg::in_item_t mk_start(int spd, int top, longint tgt);
    srpg_pkg::in_item_t it;
    it = mk(srpg_pkg::KIND_START);
    it.start_speed = 11'(spd); it.top_speed = 11'(top); it.step_target = 32'(tgt);
    return it;
  endfunction

  // a tick with encoder close to plausible so step counts stay sane
  function automatic srpg_pkg::in_item_t mk_tick(bit stalled);
    srpg_pkg::in_item_t it;
    it = mk(srpg_pkg::KIND_TICK);
    it.encoder_count = $signed(sb.origin) + $signed($urandom_range(4000) - 2000);
    it.encoder_speed = stalled ? 16'($urandom_range(20)) : 16'($urandom_range(65535, 2000));
    return it;
  endfunction

  task automatic random_move(int budget, ref int sent);
    srpg_pkg::in_item_t it;
    int n;
    send(mk_start($urandom_range(60), $urandom_range(2047), $urandom_range(300, 1)));
    sent++;
    n = $urandom_range(budget, 5);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0: it = mk(srpg_pkg::KIND_STOP);
        1, 2: it = mk_tick($urandom_range(1));
        3: it = mk(2'($urandom_range(3)));
        default: it = mk(srpg_pkg::KIND_PULSE);
      endcase
      send(it);
      sent++;
    end
  endtask

  initial begin
    srpg_pkg::in_item_t it;
    int sent;
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, each kind, idle pulse/tick, zero targets
    send(mk(srpg_pkg::KIND_PULSE));
    send(mk(srpg_pkg::KIND_TICK));
    send(mk(srpg_pkg::KIND_STOP));
    send(mk_start(0, 2047, 32'hFFFF_FFFF));
    for (int i = 0; i < 6; i++) send(mk(srpg_pkg::KIND_PULSE));
    it = mk(srpg_pkg::KIND_TICK); it.encoder_count = 32'sh7FFF_FFFF; send(it);
    it = mk(srpg_pkg::KIND_TICK); it.encoder_count = 32'sh8000_0000;
    it.encoder_speed = 16'hFFFF;
    send(it);
    send(mk_start(2047, 0, 0));
    send(mk(srpg_pkg::KIND_PULSE));
    send(mk_start(10, 5, 3));
    for (int i = 0; i < 4; i++) send(mk(srpg_pkg::KIND_PULSE));
    // stall detection past its limit
    it = mk_start(100, 200, 1000); it.encoder_count = 0; send(it);
    for (int i = 0; i < StallLim + 2; i++) begin
      it = mk(srpg_pkg::KIND_TICK); it.encoder_count = i; it.encoder_speed = 0; send(it);
    end
    drain();

    // register settings: low extremes (zero rates, zero divisor)
    write_cfg(srpg_pkg::REG_SEG1_TOP, 0); write_cfg(srpg_pkg::REG_SEG2_TOP, 5);
    write_cfg(srpg_pkg::REG_SEG3_TOP, 2047);
    write_cfg(srpg_pkg::REG_SEG1_RATE, 0); write_cfg(srpg_pkg::REG_SEG2_RATE, 1);
    write_cfg(srpg_pkg::REG_SEG3_RATE, 0);
    write_cfg(srpg_pkg::REG_LOW_FREQ, 0); write_cfg(srpg_pkg::REG_FREQ_IDX, 0);
    send(mk_start(0, 30, 50));
    for (int i = 0; i < 40; i++) send(mk(srpg_pkg::KIND_PULSE));
    send(mk_start(3, 2047, 32'hFFFF_FFFF));
    for (int i = 0; i < 20; i++) send(mk(srpg_pkg::KIND_PULSE));
    drain();

    sent = 0;
    for (int cfgset = 0; cfgset < 4; cfgset++) begin
      case (cfgset)
        0: begin
          write_cfg(srpg_pkg::REG_SEG1_TOP, 40); write_cfg(srpg_pkg::REG_SEG2_TOP, 90);
          write_cfg(srpg_pkg::REG_SEG3_TOP, 150); write_cfg(srpg_pkg::REG_SEG1_RATE, 1);
          write_cfg(srpg_pkg::REG_SEG2_RATE, 2); write_cfg(srpg_pkg::REG_SEG3_RATE, 3);
          write_cfg(srpg_pkg::REG_LOW_FREQ, 1); write_cfg(srpg_pkg::REG_FREQ_IDX, 1);
        end
        1: begin
          write_cfg(srpg_pkg::REG_SEG1_RATE, 255); write_cfg(srpg_pkg::REG_SEG2_RATE, 255);
          write_cfg(srpg_pkg::REG_SEG3_RATE, 255); write_cfg(srpg_pkg::REG_LOW_FREQ, 65535);
          write_cfg(srpg_pkg::REG_FREQ_IDX, 1023); write_cfg(srpg_pkg::REG_SEG3_TOP, 2047);
        end
        2: begin
          write_cfg(srpg_pkg::REG_SEG1_TOP, srpg_pkg::SEG1_TOP_RST);
          write_cfg(srpg_pkg::REG_SEG2_TOP, srpg_pkg::SEG2_TOP_RST);
          write_cfg(srpg_pkg::REG_SEG3_TOP, srpg_pkg::SEG3_TOP_RST);
          write_cfg(srpg_pkg::REG_SEG1_RATE, srpg_pkg::SEG1_RATE_RST);
          write_cfg(srpg_pkg::REG_SEG2_RATE, srpg_pkg::SEG2_RATE_RST);
          write_cfg(srpg_pkg::REG_SEG3_RATE, srpg_pkg::SEG3_RATE_RST);
          write_cfg(srpg_pkg::REG_LOW_FREQ, srpg_pkg::LOW_FREQ_RST);
          write_cfg(srpg_pkg::REG_FREQ_IDX, srpg_pkg::FREQ_IDX_RST);
        end
        default: for (int r = 0; r < 8; r++) write_cfg(3'(r), $urandom);
      endcase
      if (cfgset == 1) begin
        // no random idles, and hold the receiver off while items pile up
        send_idle_pct = 0; recv_idle_pct = 0;
        fork
          begin
            hold_recv = 1;
            repeat (600) @(negedge clk);
            hold_recv = 0;
          end
          random_move(30, sent);
        join
        send_idle_pct = 26; recv_idle_pct = 26;
      end
      while (sent < 190 * (cfgset + 1)) random_move(50, sent);
      drain();
    end

    $display("moves %0d, pulses %0d, ticks %0d, stops %0d; %0d status items checked",
             n_starts, n_pulses, n_ticks, n_stops, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

`default_nettype wire
